@@ hw/rtl/plli_pkg.sv @@
// shared types and constants for the piecewise linear interpolation table
package plli_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 16;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(TABLE_DEPTH);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] ST_INTERP   = 3'd0;
  localparam logic [2:0] ST_LOW      = 3'd1;
  localparam logic [2:0] ST_HIGH     = 3'd2;
  localparam logic [2:0] ST_FEW      = 3'd3;
  localparam logic [2:0] ST_UNSORTED = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RDL,
    S_SCAN,
    S_MUL,
    S_DIVST,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [2*DATA_W-1:0]   dividend;
    logic [DATA_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_W-1:0]     quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/plli_in_if.sv @@
// request channel: breakpoint loads and queries
interface plli_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [3:0]         point_index;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] query_x;

  modport source (output valid, opcode, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, opcode, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

@@ hw/rtl/plli_out_if.sv @@
// result channel: interpolated value and status
interface plli_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_y;
  logic [2:0]         status;

  modport source (output valid, result_y, status, input ready);
  modport sink   (input valid, result_y, status, output ready);
endinterface

@@ hw/rtl/plli_div.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit 16 bits
module plli_div (
  input  logic               clk,
  input  logic               rst,
  input  plli_pkg::div_req_t req,
  output plli_pkg::div_rsp_t rsp
);
  import plli_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    lo;
  logic [DATA_W-1:0]    den;
  logic [DATA_W-1:0]    quot;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 fits;

  assign trial = {rem, lo[DATA_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // high half starts below the divisor, so the remainder stays in 16 bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[2*DATA_W-1:DATA_W];
      lo  <= req.dividend[DATA_W-1:0];
      den <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo   <= {lo[DATA_W-2:0], 1'b0};
      quot <= {quot[DATA_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

@@ hw/rtl/piecewise_linear_lut_interp_unit.sv @@
// top level of the piecewise linear interpolation table
//
// usage
// - req channel (valid/ready): opcode 0 loads breakpoint (point_x, point_y) into
//   slot point_index and gives no result; opcode 1 asks for y at query_x
// - rsp channel (valid/ready): one transfer per query, result_y plus status
//   (0 interpolated, 1 clamped low, 2 clamped high, 3 too few points, 4 unsorted)
// - cfg_we/cfg_wdata write point_count, the number of breakpoints in use;
//   write it only while no query is in flight
// - a load is written into the table when it transfers; a query with too few points
//   goes straight to the done state, one that clamps low reads the first table entry,
//   one that clamps high the last entry too, and one that interpolates reads both,
//   scans up to 15 entries at one per cycle, then multiplies, starts the divider
//   and waits for the bit-serial divide; one query at a time, and the next request
//   is taken as soon as the previous result sits in the output register
// - when the receiver stalls, a finished result waits in the done state until
//   the output register frees up
// - reset clears point_count and control; table contents stay undefined until
//   loaded, and no clearing pass is needed
module piecewise_linear_lut_interp_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  plli_in_if.sink    req,
  plli_out_if.source rsp
);
  import plli_pkg::*;

  localparam logic signed [DATA_W+1:0] SAT_HI = 18'sd32767;
  localparam logic signed [DATA_W+1:0] SAT_LO = -18'sd32768;

  state_t state, state_next;

  // configuration
  logic [CNT_W-1:0] point_count;
  logic [CNT_W-1:0] n_sat;

  // table memory, {x, y} per slot, registered read
  logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
  logic [2*DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic signed [DATA_W-1:0] cur_x, cur_y;

  // query context
  logic signed [DATA_W-1:0] q;
  logic [CNT_W-1:0]         n;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         k;
  logic signed [DATA_W-1:0] prev_x, prev_y;
  logic                     hit;

  // segment math
  logic signed [DATA_W-1:0]   seg_y1;
  logic signed [DATA_W:0]     seg_dq;
  logic signed [DATA_W:0]     seg_dy;
  logic [DATA_W-1:0]          seg_den;
  logic signed [2*DATA_W+1:0] prod;
  logic signed [2*DATA_W+1:0] prod_neg;
  logic signed [DATA_W:0]     pair_sum;
  logic signed [DATA_W:0]     pair_adj;
  logic signed [DATA_W:0]     avg;
  logic signed [DATA_W+1:0]   quot_mag;
  logic signed [DATA_W+1:0]   quot_s;
  logic signed [DATA_W+1:0]   interp;
  logic signed [DATA_W-1:0]   interp_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_start;

  // pending result and output register
  logic signed [DATA_W-1:0] res_y;
  logic [2:0]               res_st;
  logic                     rsp_valid;
  logic signed [DATA_W-1:0] rsp_y;
  logic [2:0]               rsp_st;
  logic                     slot_free;
  logic                     req_ready;
  logic                     req_xfer;

  assign req_xfer  = req.valid && req_ready;
  assign slot_free = !rsp_valid || rsp.ready;
  assign n_sat     = (point_count > MAX_COUNT) ? MAX_COUNT : point_count;
  assign last_idx  = IDX_W'(n - 1'b1);

  assign cur_x = rd_data[2*DATA_W-1:DATA_W];
  assign cur_y = rd_data[DATA_W-1:0];

  // segment [prev, cur] holds the query
  assign hit = (q >= prev_x) && (q <= cur_x);

  // equal segment ends: halve the sum, rounding toward zero
  assign pair_sum = DATA_W'(0) + (DATA_W+1)'(prev_y) + (DATA_W+1)'(cur_y);
  assign pair_adj = pair_sum + {{DATA_W{1'b0}}, pair_sum[DATA_W]};
  assign avg      = pair_adj >>> 1;

  // divider works on magnitudes; dq is never negative so the sign is dy's
  assign prod_neg = -prod;
  assign quot_mag = {2'b00, div_rsp.quotient};
  assign quot_s   = prod[2*DATA_W+1] ? -quot_mag : quot_mag;
  assign interp   = (DATA_W+2)'(seg_y1) + quot_s;
  assign interp_sat = (interp > SAT_HI) ? SAT_HI[DATA_W-1:0] :
                      (interp < SAT_LO) ? SAT_LO[DATA_W-1:0] : interp[DATA_W-1:0];

  assign div_req.start    = div_start;
  assign div_req.dividend = prod[2*DATA_W+1] ? prod_neg[2*DATA_W-1:0] : prod[2*DATA_W-1:0];
  assign div_req.divisor  = seg_den;

  plli_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  // table memory: loads write, the scan reads one entry per cycle
  always_ff @(posedge clk) begin
    if (req_xfer && req.opcode == OP_LOAD) begin
      mem[req.point_index] <= {req.point_x, req.point_y};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_addr    = '0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid && req.opcode == OP_QUERY) begin
          state_next = (n_sat < CNT_W'(2)) ? S_DONE : S_RD0;
        end
      end
      S_RD0: begin
        // first entry on the read port, fetch the last one
        rd_addr    = last_idx;
        state_next = (q <= cur_x) ? S_DONE : S_RDL;
      end
      S_RDL: begin
        rd_addr    = IDX_W'(1);
        state_next = (q >= cur_x) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        rd_addr = k + 1'b1;
        if (hit) begin
          state_next = (prev_x == cur_x) ? S_DONE : S_MUL;
        end else if (k == last_idx) begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        state_next = S_DIVST;
      end
      S_DIVST: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_xfer && req.opcode == OP_QUERY) begin
          q      <= req.query_x;
          n      <= n_sat;
          res_y  <= '0;
          res_st <= ST_FEW;
        end
      end
      S_RD0: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        res_y  <= cur_y;
        res_st <= ST_LOW;
      end
      S_RDL: begin
        // last y stays in res_y for the clamp and the unsorted fault
        res_y  <= cur_y;
        res_st <= ST_HIGH;
        k      <= IDX_W'(1);
      end
      S_SCAN: begin
        if (hit) begin
          seg_y1  <= prev_y;
          seg_dq  <= (DATA_W+1)'(q) - (DATA_W+1)'(prev_x);
          seg_dy  <= (DATA_W+1)'(cur_y) - (DATA_W+1)'(prev_y);
          seg_den <= DATA_W'((DATA_W+1)'(cur_x) - (DATA_W+1)'(prev_x));
          res_y   <= avg[DATA_W-1:0];
          res_st  <= ST_INTERP;
        end else begin
          if (k == last_idx) begin
            res_st <= ST_UNSORTED;
          end
          prev_x <= cur_x;
          prev_y <= cur_y;
          k      <= k + 1'b1;
        end
      end
      S_MUL: begin
        prod <= seg_dq * seg_dy;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_y <= interp_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      rsp_y  <= res_y;
      rsp_st <= res_st;
    end
  end

  assign req.ready    = req_ready;
  assign rsp.valid    = rsp_valid;
  assign rsp.result_y = rsp_y;
  assign rsp.status   = rsp_st;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> {1'b0, k} < n)
    else $error("scan index beyond breakpoints in use");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result presented without a finished query");
`endif

endmodule
